FILE: rtl/core/hsl_pkg.sv
package hsl_pkg;

  // default channel width, unsigned fraction of one
  localparam int unsigned CHANNEL_BITS = 16;

  // hue in 1/64 degree steps, one full turn is 360 * 64
  localparam int unsigned HUE_W      = 15;
  localparam int unsigned HUE_PERIOD = 23040;

  // one unit of k: 30 degrees for hsl, 60 degrees for hsv
  localparam int unsigned HSL_UNIT = 1920;
  localparam int unsigned HSV_UNIT = 3840;

  // hsl unit split into an odd factor and a power of two: 1920 = 15 << 7
  localparam int unsigned UNIT_ODD = 15;
  localparam int unsigned UNIT_POW = 7;

  // per-channel hue offsets n * unit
  localparam int unsigned HSL_OFS_RED   = 0 * HSL_UNIT;
  localparam int unsigned HSL_OFS_GREEN = 8 * HSL_UNIT;
  localparam int unsigned HSL_OFS_BLUE  = 4 * HSL_UNIT;
  localparam int unsigned HSV_OFS_RED   = 5 * HSV_UNIT;
  localparam int unsigned HSV_OFS_GREEN = 3 * HSV_UNIT;
  localparam int unsigned HSV_OFS_BLUE  = 1 * HSV_UNIT;

  // hue coefficient, covers -1920 .. 3840
  localparam int unsigned COEF_W = 13;

  // register stages from input transfer to output register
  localparam int unsigned PIPE_DEPTH = 6;

  typedef enum logic {
    MODE_HSL = 1'b0,
    MODE_HSV = 1'b1
  } mode_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t red;
    coef_t green;
    coef_t blue;
  } coef_set_t;

endpackage

FILE: rtl/core/hsl_in_if.sv
interface hsl_in_if #(
  parameter int unsigned W = hsl_pkg::CHANNEL_BITS
);
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [hsl_pkg::HUE_W-1:0]  hue;
  logic [W-1:0]               saturation;
  logic [W-1:0]               lightness_or_value;
  logic [W-1:0]               alpha_in;

  modport source (
    output valid, action, hue, saturation, lightness_or_value, alpha_in,
    input  ready
  );

  modport sink (
    input  valid, action, hue, saturation, lightness_or_value, alpha_in,
    output ready
  );
endinterface

FILE: rtl/core/hsl_out_if.sv
interface hsl_out_if #(
  parameter int unsigned W = hsl_pkg::CHANNEL_BITS
);
  logic         valid;
  logic         ready;
  logic [W-1:0] red;
  logic [W-1:0] green;
  logic [W-1:0] blue;
  logic [W-1:0] alpha_out;

  modport source (
    output valid, red, green, blue, alpha_out,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, alpha_out,
    output ready
  );
endinterface

FILE: rtl/core/hsl_hue_dec.sv
module hsl_hue_dec (
  input  hsl_pkg::mode_e             mode_i,
  input  logic [hsl_pkg::HUE_W-1:0]  hue_i,
  output hsl_pkg::coef_set_t         coef_o
);

  localparam int unsigned KW = 17;
  localparam int unsigned SW = KW + 1;

  localparam logic [KW-1:0] PERIOD = KW'(hsl_pkg::HUE_PERIOD);

  localparam logic signed [SW-1:0] HSL_HI  = SW'(hsl_pkg::HSL_UNIT);
  localparam logic signed [SW-1:0] HSL_LO  = -HSL_HI;
  localparam logic signed [SW-1:0] HSL_K3  = SW'(3 * hsl_pkg::HSL_UNIT);
  localparam logic signed [SW-1:0] HSL_K9  = SW'(9 * hsl_pkg::HSL_UNIT);
  localparam logic signed [SW-1:0] HSV_HI  = SW'(hsl_pkg::HSV_UNIT);
  localparam logic signed [SW-1:0] HSV_LO  = '0;
  localparam logic signed [SW-1:0] HSV_K4  = SW'(4 * hsl_pkg::HSV_UNIT);

  logic [hsl_pkg::HUE_W-1:0] hue_red;
  logic [KW-1:0]             hue_ext;

  // piecewise-linear ramp of one channel, clamped to its plateau values
  function automatic hsl_pkg::coef_t chan_coef(input hsl_pkg::mode_e mode,
                                               input logic [KW-1:0] hr,
                                               input logic [KW-1:0] ofs);
    logic [KW-1:0]          k_sum;
    logic [KW-1:0]          k;
    logic signed [SW-1:0]   ks;
    logic signed [SW-1:0]   f;
    logic signed [SW-1:0]   alt;
    logic signed [SW-1:0]   lo;
    logic signed [SW-1:0]   hi;
    logic signed [SW-1:0]   res;
    k_sum = hr + ofs;
    k     = (k_sum >= PERIOD) ? k_sum - PERIOD : k_sum;
    ks    = $signed({1'b0, k});
    if (mode == hsl_pkg::MODE_HSV) begin
      f   = ks;
      alt = HSV_K4 - ks;
      lo  = HSV_LO;
      hi  = HSV_HI;
    end else begin
      f   = ks - HSL_K3;
      alt = HSL_K9 - ks;
      lo  = HSL_LO;
      hi  = HSL_HI;
    end
    res = (alt < f) ? alt : f;
    if (res > hi) begin
      res = hi;
    end
    if (res < lo) begin
      res = lo;
    end
    return res[hsl_pkg::COEF_W-1:0];
  endfunction

  // bring hue into one turn, it is below two turns
  assign hue_red = (hue_i >= hsl_pkg::HUE_W'(hsl_pkg::HUE_PERIOD)) ?
                   hue_i - hsl_pkg::HUE_W'(hsl_pkg::HUE_PERIOD) : hue_i;
  assign hue_ext = KW'(hue_red);

  // per-channel offsets depend on the mode
  always_comb begin
    if (mode_i == hsl_pkg::MODE_HSV) begin
      coef_o.red   = chan_coef(mode_i, hue_ext, KW'(hsl_pkg::HSV_OFS_RED));
      coef_o.green = chan_coef(mode_i, hue_ext, KW'(hsl_pkg::HSV_OFS_GREEN));
      coef_o.blue  = chan_coef(mode_i, hue_ext, KW'(hsl_pkg::HSV_OFS_BLUE));
    end else begin
      coef_o.red   = chan_coef(mode_i, hue_ext, KW'(hsl_pkg::HSL_OFS_RED));
      coef_o.green = chan_coef(mode_i, hue_ext, KW'(hsl_pkg::HSL_OFS_GREEN));
      coef_o.blue  = chan_coef(mode_i, hue_ext, KW'(hsl_pkg::HSL_OFS_BLUE));
    end
  end

endmodule

FILE: rtl/core/hsl_ch_round.sv
module hsl_ch_round #(
  parameter int unsigned W = hsl_pkg::CHANNEL_BITS
) (
  input  hsl_pkg::mode_e          mode_i,
  input  logic [W-1:0]            base_i,
  input  logic signed [2*W+13:0]  term_i,
  output logic [W+3:0]            y_o
);

  localparam int unsigned XW = 2 * W + 15;
  localparam int unsigned SH = W + hsl_pkg::UNIT_POW;

  logic [XW-1:0]         b_ext;
  logic [XW-1:0]         hsl_x;
  logic [XW-1:0]         sum_x;
  logic signed [XW-1:0]  t_ext;
  logic signed [XW-1:0]  x;

  // base * den plus half a den, hsv den is twice the hsl den
  assign b_ext = XW'(base_i);
  assign hsl_x = ((b_ext * XW'(hsl_pkg::HSL_UNIT)) << W) +
                 (XW'(hsl_pkg::HSL_UNIT) << (W - 1));
  assign sum_x = (mode_i == hsl_pkg::MODE_HSV) ? (hsl_x << 1) : hsl_x;

  // subtract the hue term, the result is never negative
  assign t_ext = XW'(term_i);
  assign x     = $signed(sum_x) - t_ext;

  // drop the power-of-two part of the den, the odd factor is left
  assign y_o = (mode_i == hsl_pkg::MODE_HSV) ? x[SH+1 +: W+4] : x[SH +: W+4];

endmodule

FILE: rtl/core/hsl_ch_fix.sv
module hsl_ch_fix #(
  parameter int unsigned W = hsl_pkg::CHANNEL_BITS
) (
  input  logic [W+3:0]  y_i,
  input  logic [W:0]    q0_i,
  output logic [W-1:0]  ch_o
);

  logic [W+4:0] rem;
  logic [W+1:0] q;

  // estimate is at most one short of the true quotient
  assign rem = (W+5)'(y_i) - ((W+5)'(q0_i) * (W+5)'(hsl_pkg::UNIT_ODD));
  assign q   = (W+2)'(q0_i) + (W+2)'(rem >= (W+5)'(hsl_pkg::UNIT_ODD));

  // full scale saturates to the largest code
  assign ch_o = (q[W+1:W] != 2'b00) ? '1 : q[W-1:0];

endmodule

FILE: rtl/core/hsl_hsv_to_rgb.sv
// hsl / hsv to rgb converter, six register stages, one pixel per transfer
// throughput: one pixel per clock; a stall backs up stage by stage, bubbles fill in
// the multiplier on the reciprocal of the odd divisor sets the stage count
// reset clears only the stage valid bits, data registers are not reset
module hsl_hsv_to_rgb #(
  parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsl_in_if.sink    in_i,
  hsl_out_if.source out_o
);

  localparam int unsigned W     = CHANNEL_BITS;
  localparam int unsigned PD    = hsl_pkg::PIPE_DEPTH;
  localparam int unsigned TW    = 2 * W + 14;
  localparam int unsigned YW    = W + 4;
  localparam int unsigned RW    = W + 2;
  localparam int unsigned RSH   = W + 5;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << RSH) / hsl_pkg::UNIT_ODD);

  // stage control
  logic [PD-1:0] vld_q;
  logic [PD-1:0] rdy;

  // stage 1: hue coefficients and multiplicands
  hsl_pkg::mode_e     mode1_q;
  hsl_pkg::coef_set_t coef1_q;
  logic [W-1:0]       sat1_q;
  logic [W-1:0]       m1_q;
  logic [W-1:0]       base1_q;
  logic [W-1:0]       alpha1_q;

  // stage 2: saturation times chroma base
  hsl_pkg::mode_e     mode2_q;
  hsl_pkg::coef_set_t coef2_q;
  logic [2*W-1:0]     prod2_q;
  logic [W-1:0]       base2_q;
  logic [W-1:0]       alpha2_q;

  // stage 3: hue term per channel
  hsl_pkg::mode_e     mode3_q;
  logic signed [TW-1:0] term3_q [3];
  logic [W-1:0]       base3_q;
  logic [W-1:0]       alpha3_q;

  // stage 4: numerator over power-of-two part of the den
  logic [YW-1:0]      y4_q [3];
  logic [W-1:0]       alpha4_q;

  // stage 5: quotient estimate
  logic [YW-1:0]      y5_q [3];
  logic [W:0]         q0_5_q [3];
  logic [W-1:0]       alpha5_q;

  // stage 6: output register
  logic [W-1:0]       ch6_q [3];
  logic [W-1:0]       alpha6_q;

  // combinational stage inputs
  hsl_pkg::mode_e     mode_in;
  hsl_pkg::coef_set_t coef_in;
  logic [W:0]         one_minus;
  logic [W-1:0]       m_in;
  logic signed [TW-1:0] term_d [3];
  logic signed [hsl_pkg::COEF_W-1:0] coef2_a [3];
  logic [YW-1:0]      y_d [3];
  logic [W:0]         q0_d [3];
  logic [W-1:0]       ch_d [3];

  // ready chain, a stage loads when empty or when it moves on
  always_comb begin
    rdy[PD-1] = !vld_q[PD-1] || out_o.ready;
    for (int i = PD - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign in_i.ready = rdy[0];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int i = 1; i < PD; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // stage 1 logic: hue decode and min(l, 1 - l) for hsl
  assign mode_in   = hsl_pkg::mode_e'(in_i.action);
  assign one_minus = (W+1)'(1) << W;

  always_comb begin
    m_in = in_i.lightness_or_value;
    if (mode_in == hsl_pkg::MODE_HSL) begin
      if ((one_minus - {1'b0, in_i.lightness_or_value}) < {1'b0, in_i.lightness_or_value}) begin
        m_in = W'(one_minus - {1'b0, in_i.lightness_or_value});
      end
    end
  end

  hsl_hue_dec u_hue_dec (
    .mode_i (mode_in),
    .hue_i  (in_i.hue),
    .coef_o (coef_in)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_i.valid) begin
      mode1_q  <= mode_in;
      coef1_q  <= coef_in;
      sat1_q   <= in_i.saturation;
      m1_q     <= m_in;
      base1_q  <= in_i.lightness_or_value;
      alpha1_q <= in_i.alpha_in;
    end
  end

  // stage 2: one shared multiplier for all channels
  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_q[0]) begin
      mode2_q  <= mode1_q;
      coef2_q  <= coef1_q;
      prod2_q  <= (2*W)'(sat1_q) * (2*W)'(m1_q);
      base2_q  <= base1_q;
      alpha2_q <= alpha1_q;
    end
  end

  // stage 3: signed hue term per channel
  assign coef2_a[0] = coef2_q.red;
  assign coef2_a[1] = coef2_q.green;
  assign coef2_a[2] = coef2_q.blue;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    assign term_d[c] = $signed({1'b0, prod2_q}) * coef2_a[c];

    hsl_ch_round #(
      .W (W)
    ) u_round (
      .mode_i (mode3_q),
      .base_i (base3_q),
      .term_i (term3_q[c]),
      .y_o    (y_d[c])
    );

    // reciprocal multiply by 1/15, keep the integer part
    logic [YW+RW-1:0] recip_prod;
    assign recip_prod = (YW+RW)'(y4_q[c]) * (YW+RW)'(RECIP);
    assign q0_d[c]    = recip_prod[RSH +: W+1];

    hsl_ch_fix #(
      .W (W)
    ) u_fix (
      .y_i  (y5_q[c]),
      .q0_i (q0_5_q[c]),
      .ch_o (ch_d[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vld_q[1]) begin
      mode3_q  <= mode2_q;
      base3_q  <= base2_q;
      alpha3_q <= alpha2_q;
      for (int c = 0; c < 3; c++) begin
        term3_q[c] <= term_d[c];
      end
    end
  end

  // stage 4: rounded numerator, shifted down
  always_ff @(posedge clk_i) begin
    if (rdy[3] && vld_q[2]) begin
      alpha4_q <= alpha3_q;
      for (int c = 0; c < 3; c++) begin
        y4_q[c] <= y_d[c];
      end
    end
  end

  // stage 5: quotient estimate by the odd factor
  always_ff @(posedge clk_i) begin
    if (rdy[4] && vld_q[3]) begin
      alpha5_q <= alpha4_q;
      for (int c = 0; c < 3; c++) begin
        y5_q[c]   <= y4_q[c];
        q0_5_q[c] <= q0_d[c];
      end
    end
  end

  // stage 6: correction, clamp and output register
  always_ff @(posedge clk_i) begin
    if (rdy[5] && vld_q[4]) begin
      alpha6_q <= alpha5_q;
      for (int c = 0; c < 3; c++) begin
        ch6_q[c] <= ch_d[c];
      end
    end
  end

  assign out_o.valid     = vld_q[PD-1];
  assign out_o.red       = ch6_q[0];
  assign out_o.green     = ch6_q[1];
  assign out_o.blue      = ch6_q[2];
  assign out_o.alpha_out = alpha6_q;

`ifndef SYNTHESIS
  // input is held off only when every stage is full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == !((&vld_q) && !out_o.ready))
    else $error("ready chain does not match pipeline occupancy");

  // hsl ramp stays inside plus or minus one unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && (mode1_q == hsl_pkg::MODE_HSL)) |->
      ((coef1_q.red   >= -$signed(14'(hsl_pkg::HSL_UNIT))) &&
       (coef1_q.red   <=  $signed(14'(hsl_pkg::HSL_UNIT))) &&
       (coef1_q.green >= -$signed(14'(hsl_pkg::HSL_UNIT))) &&
       (coef1_q.green <=  $signed(14'(hsl_pkg::HSL_UNIT))) &&
       (coef1_q.blue  >= -$signed(14'(hsl_pkg::HSL_UNIT))) &&
       (coef1_q.blue  <=  $signed(14'(hsl_pkg::HSL_UNIT)))))
    else $error("hsl coefficient out of range");

  // reciprocal estimate never overshoots and is at most one short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |->
      (((W+5)'(q0_5_q[0]) * (W+5)'(hsl_pkg::UNIT_ODD) <= (W+5)'(y5_q[0])) &&
       ((W+5)'(y5_q[0]) - (W+5)'(q0_5_q[0]) * (W+5)'(hsl_pkg::UNIT_ODD) <
        (W+5)'(2 * hsl_pkg::UNIT_ODD))))
    else $error("quotient estimate outside correction range");
`endif

endmodule
